/* sv/assert_macros.svh */
// Assertion helpers used by the checker file dhno_chk.
// Every property is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define DHNO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dhno: property failed");

// Same-cycle implication.
`define DHNO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhno: implication failed");

// Next-cycle implication.
`define DHNO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhno: next-cycle implication failed");

`endif

/* sv/dhno_pkg.sv */
package dhno_pkg;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_OFFSET = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

    // Golden-ratio mix applied to the frame count when seeding
    localparam logic [31:0] SEED_MIX = 32'h9e37_79b1;

    // Mid-point of the 24-bit noise value (0.5 in Q0.24)
    localparam logic [23:0] NOISE_HALF = 24'h80_0000;

    // Decay register reset value, 0.95 in Q0.16
    localparam logic [15:0] DECAY_RESET = 16'd62259;

    // Register map
    localparam int unsigned ADDR_W  = 3;
    localparam logic        REG_DECAY = 1'b0;

    // Input item kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] frame_number;
        logic [15:0] shake_frames;
        logic [23:0] shake_intensity;
    } item_t;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic               shaking;
    } result_t;

endpackage

/* sv/dhno_mul.sv */
module dhno_mul (
    input  logic        clk,
    input  logic        load,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    // Hold the product until the sequencer issues the next operation
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* sv/dhno_seq.sv */
module dhno_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dhno_pkg::item_t     item,
    input  logic [15:0]         decay_factor,
    output logic                res_valid,
    input  logic                res_ready,
    output dhno_pkg::result_t   res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEED  = 4'd1;
    localparam logic [3:0] ST_SEEDW = 4'd2;
    localparam logic [3:0] ST_HASH  = 4'd3;
    localparam logic [3:0] ST_AXIS  = 4'd4;
    localparam logic [3:0] ST_MULO  = 4'd5;
    localparam logic [3:0] ST_STO   = 4'd6;
    localparam logic [3:0] ST_DECAY = 4'd7;
    localparam logic [3:0] ST_DECW  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // Control and shake state
    logic [3:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        axis_reg, axis_next;
    logic [15:0] frames_left_reg, frames_left_next;
    logic [23:0] amp_reg, amp_next;
    logic [31:0] seed_reg, seed_next;

    // Working payload
    logic [31:0] frame_reg, frame_next;
    logic [31:0] common_reg, common_next;
    logic        neg_reg, neg_next;
    logic [23:0] off_x_reg, off_x_next;
    logic [23:0] off_y_reg, off_y_next;
    logic        shaking_reg, shaking_next;

    // Shared multiplier
    logic        mul_load;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic [7:0]  hash_byte;
    logic [31:0] hash_base;
    logic [31:0] byte_src;
    logic [23:0] noise_top;
    logic        noise_neg;
    logic [23:0] noise_mag;
    logic [23:0] off_mag;
    logic [23:0] off_val;

    dhno_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Byte feed: frame word then seed word, low byte first; axis word afterwards
    assign byte_src = cnt_reg[2] ? seed_reg : frame_reg;

    always_comb
    begin
        hash_byte = 8'd0;
        hash_base = prod[31:0];
        if (state_reg == ST_HASH)
        begin
            hash_byte = byte_src[{cnt_reg[1:0], 3'b000} +: 8];
            if (cnt_reg == 3'd0)
            begin
                hash_base = dhno_pkg::FNV_OFFSET;
            end
        end
        else if (state_reg == ST_AXIS)
        begin
            if (cnt_reg == 3'd0)
            begin
                hash_byte = {7'd0, axis_reg};
                if (axis_reg)
                begin
                    hash_base = common_reg;
                end
            end
        end
    end

    // Noise: top 24 hash bits less one half, as sign and magnitude
    assign noise_top = prod[31:8];
    assign noise_neg = ~prod[31];
    assign noise_mag = noise_neg ? (dhno_pkg::NOISE_HALF - noise_top)
                                 : {1'b0, noise_top[22:0]};

    assign off_mag = prod[47:24];
    assign off_val = neg_reg ? (24'd0 - off_mag) : off_mag;

    always_comb
    begin
        mul_load = 1'b1;
        unique case (state_reg)
            ST_SEED:
            begin
                mul_a = {16'd0, frames_left_reg};
                mul_b = dhno_pkg::SEED_MIX;
            end
            ST_HASH, ST_AXIS:
            begin
                mul_a = hash_base ^ {24'd0, hash_byte};
                mul_b = dhno_pkg::FNV_PRIME;
            end
            ST_MULO:
            begin
                mul_a = {8'd0, noise_mag};
                mul_b = {8'd0, amp_reg};
            end
            ST_DECAY:
            begin
                mul_a = {8'd0, amp_reg};
                mul_b = {16'd0, decay_factor};
            end
            default:
            begin
                mul_load = 1'b0;
                mul_a    = 32'd0;
                mul_b    = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        axis_next        = axis_reg;
        frames_left_next = frames_left_reg;
        amp_next         = amp_reg;
        seed_next        = seed_reg;
        frame_next       = frame_reg;
        common_next      = common_reg;
        neg_next         = neg_reg;
        off_x_next       = off_x_reg;
        off_y_next       = off_y_reg;
        shaking_next     = shaking_reg;
        item_ready       = 1'b0;
        res_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    frame_next = item.frame_number;
                    if (item.mode == dhno_pkg::MODE_START)
                    begin
                        frames_left_next = item.shake_frames;
                        amp_next         = item.shake_intensity;
                        state_next       = ST_SEED;
                    end
                    else if (frames_left_reg == 16'd0)
                    begin
                        off_x_next   = 24'd0;
                        off_y_next   = 24'd0;
                        shaking_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = 3'd0;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_SEED:
            begin
                state_next = ST_SEEDW;
            end
            ST_SEEDW:
            begin
                seed_next  = prod[31:0] ^ {8'd0, amp_reg};
                state_next = ST_IDLE;
            end
            ST_HASH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    cnt_next   = 3'd0;
                    axis_next  = 1'b0;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                // Keep the hash over frame and seed; both axes start from it
                if (cnt_reg == 3'd0 && !axis_reg)
                begin
                    common_next = prod[31:0];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_MULO;
                end
            end
            ST_MULO:
            begin
                neg_next   = noise_neg;
                state_next = ST_STO;
            end
            ST_STO:
            begin
                if (!axis_reg)
                begin
                    off_x_next = off_val;
                    axis_next  = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = ST_AXIS;
                end
                else
                begin
                    off_y_next = off_val;
                    state_next = ST_DECAY;
                end
            end
            ST_DECAY:
            begin
                state_next = ST_DECW;
            end
            ST_DECW:
            begin
                amp_next         = prod[39:16];
                frames_left_next = frames_left_reg - 16'd1;
                shaking_next     = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= 3'd0;
            axis_reg        <= 1'b0;
            frames_left_reg <= 16'd0;
            amp_reg         <= 24'd0;
            seed_reg        <= 32'd0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            axis_reg        <= axis_next;
            frames_left_reg <= frames_left_next;
            amp_reg         <= amp_next;
            seed_reg        <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg   <= frame_next;
        common_reg  <= common_next;
        neg_reg     <= neg_next;
        off_x_reg   <= off_x_next;
        off_y_reg   <= off_y_next;
        shaking_reg <= shaking_next;
    end

    assign res.offset_x = off_x_reg;
    assign res.offset_y = off_y_reg;
    assign res.shaking  = shaking_reg;

endmodule

/* sv/decaying_hash_noise_offset_generator.sv */
// Screen-shake offset generator. A start transaction (mode 0) loads a shake of
// shake_frames frames at amplitude shake_intensity (unsigned Q8.16) and derives
// a noise seed from both; it returns nothing. Each tick transaction (mode 1)
// returns one result: while frames remain, offset_x and offset_y are FNV-1a
// hash noise over (frame_number, seed, axis) in [-0.5, 0.5) scaled by the
// current amplitude (signed Q8.16, truncated toward zero) and shaking is 1;
// the amplitude is then multiplied by decay_factor (Q0.16, APB address 0,
// reset 0.95) and the frame count drops by one. With no frames left a tick
// returns zeros and changes nothing. All arithmetic runs on one registered
// 32x32 multiplier, one FNV byte per cycle. An active tick holds in_ready
// low while it hashes eight shared frame/seed bytes, then for each axis four
// axis bytes and one scale, then takes one decay step before presenting its
// result; an inactive tick goes straight to its result. The result sits in
// an output register, so the next transaction is taken while it waits.
module decaying_hash_noise_offset_generator (
    input  logic                            clk,
    input  logic                            rst_n,

    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dhno_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    // Input transactions
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [31:0]                     frame_number,
    input  logic [15:0]                     shake_frames,
    input  logic [23:0]                     shake_intensity,

    // Result transactions
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [23:0]              offset_x,
    output logic signed [23:0]              offset_y,
    output logic                            shaking
);

    logic [15:0]        decay_reg, decay_next;
    logic               out_valid_reg, out_valid_next;
    dhno_pkg::result_t  out_reg;

    logic               reg_index;
    logic               cfg_write;

    dhno_pkg::item_t    item;
    dhno_pkg::result_t  res;
    logic               res_valid;
    logic               res_ready;

    // Register file: one register, word addressed
    assign pready    = 1'b1;
    assign reg_index = paddr[dhno_pkg::ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        decay_next = decay_reg;
        if (cfg_write && reg_index == dhno_pkg::REG_DECAY)
        begin
            decay_next = pwdata[15:0];
        end
    end

    assign prdata = (reg_index == dhno_pkg::REG_DECAY) ? {16'd0, decay_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= dhno_pkg::DECAY_RESET;
        end
        else
        begin
            decay_reg <= decay_next;
        end
    end

    // Pack the input fields for the sequencer
    assign item.mode            = mode;
    assign item.frame_number    = frame_number;
    assign item.shake_frames    = shake_frames;
    assign item.shake_intensity = shake_intensity;

    dhno_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid),
        .item_ready   (in_ready),
        .item         (item),
        .decay_factor (decay_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the transaction completes
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign offset_x  = out_reg.offset_x;
    assign offset_y  = out_reg.offset_y;
    assign shaking   = out_reg.shaking;

endmodule

/* sv/dhno_chk.sv */
`include "assert_macros.svh"

module dhno_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [23:0] offset_x,
    input  logic signed [23:0] offset_y,
    input  logic               shaking
);

    // A stalled result holds its payload
    `DHNO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(offset_x) && $stable(offset_y) && $stable(shaking))

    // The sequencer works on one transaction at a time
    `DHNO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // An inactive tick reports zero offsets
    `DHNO_ASSERT_IMPL(a_idle_zero, out_valid && !shaking, offset_x == 24'sd0 && offset_y == 24'sd0)

    // No result appears in the cycle right after a transaction is taken
    `DHNO_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind decaying_hash_noise_offset_generator dhno_chk u_dhno_chk (.*);

/* test/decaying_hash_noise_offset_generator_tb.sv */
// Predicts the offsets of each tick and checks them, field by field, in
// acceptance order.
class offset_scoreboard;
    dhno_pkg::result_t expected_offsets[$];

    logic [15:0] frames_left;
    logic [23:0] amplitude;
    logic [31:0] noise_seed;
    logic [15:0] decay_q16;

    int errors;
    int items_taken;
    int active_ticks;
    int results_checked;

    function new();
        frames_left     = '0;
        amplitude       = '0;
        noise_seed      = '0;
        decay_q16       = dhno_pkg::DECAY_RESET;
        errors          = 0;
        items_taken     = 0;
        active_ticks    = 0;
        results_checked = 0;
    endfunction

    task report(input string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void load_decay(input logic [15:0] value);
        decay_q16 = value;
    endfunction

    // One 32-bit word into FNV-1a, low byte first.
    function logic [31:0] fnv_word(input logic [31:0] h, input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            h = h ^ {24'd0, w[8*k +: 8]};
            h = h * dhno_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    function logic [31:0] axis_hash(input logic [31:0] frame, input logic [31:0] seed,
                                    input logic [31:0] axis);
        logic [31:0] h;
        h = fnv_word(dhno_pkg::FNV_OFFSET, frame);
        h = fnv_word(h, seed);
        return fnv_word(h, axis);
    endfunction

    // Top 24 hash bits less one half, times amplitude, truncated toward zero.
    function logic [23:0] scale_noise(input logic [31:0] h, input logic [23:0] amp);
        logic [23:0] top;
        logic [23:0] nmag;
        logic [47:0] prod;
        logic        neg;
        top = h[31:8];
        neg = (top < dhno_pkg::NOISE_HALF);
        nmag = neg ? dhno_pkg::NOISE_HALF - top : top - dhno_pkg::NOISE_HALF;
        prod = {24'd0, nmag} * {24'd0, amp};
        return neg ? 24'd0 - prod[47:24] : prod[47:24];
    endfunction

    function void take_item(input dhno_pkg::item_t it);
        dhno_pkg::result_t r;
        logic [31:0]       mixed;
        logic [39:0]       decayed;
        items_taken++;
        if (it.mode == dhno_pkg::MODE_START) begin
            frames_left = it.shake_frames;
            amplitude   = it.shake_intensity;
            mixed       = {16'd0, it.shake_frames} * dhno_pkg::SEED_MIX;
            noise_seed  = {8'd0, it.shake_intensity} ^ mixed;
        end else begin
            r = '0;
            if (frames_left != 16'd0) begin
                r.offset_x  = scale_noise(axis_hash(it.frame_number, noise_seed, 32'd0), amplitude);
                r.offset_y  = scale_noise(axis_hash(it.frame_number, noise_seed, 32'd1), amplitude);
                r.shaking   = 1'b1;
                decayed     = {16'd0, amplitude} * {24'd0, decay_q16};
                amplitude   = decayed[39:16];
                frames_left = frames_left - 16'd1;
                active_ticks++;
            end
            expected_offsets.push_back(r);
        end
    endfunction

    task check_offsets(input dhno_pkg::result_t got);
        dhno_pkg::result_t want;
        results_checked++;
        if (expected_offsets.size() == 0) begin
            report($sformatf("result x=%0d y=%0d shaking=%0b with nothing pending",
                             got.offset_x, got.offset_y, got.shaking));
        end else begin
            want = expected_offsets.pop_front();
            if (got.offset_x !== want.offset_x)
                report($sformatf("offset_x got %0d expected %0d",
                                 got.offset_x, want.offset_x));
            if (got.offset_y !== want.offset_y)
                report($sformatf("offset_y got %0d expected %0d",
                                 got.offset_y, want.offset_y));
            if (got.shaking !== want.shaking)
                report($sformatf("shaking got %0b expected %0b", got.shaking, want.shaking));
        end
    endtask
endclass

module decaying_hash_noise_offset_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real PERIOD           = 4.0;
    localparam int  RESET_CYCLES     = 11;
    localparam int  DRAIN_CYCLES     = 40;
    localparam int  QUIET_LIMIT      = 2000;  // well above the long output stall
    localparam int  LONG_STALL       = 400;
    localparam int  ITEMS_PER_PHASE  = 150;
    localparam int  PHASES           = 6;

    // Byte addresses: the decay register, and an unmapped slot right after it
    localparam int DECAY_BYTE = 4 * int'(dhno_pkg::REG_DECAY);
    localparam int SPARE_BYTE = DECAY_BYTE + 4;
    localparam logic [dhno_pkg::ADDR_W-1:0] DECAY_ADDR = DECAY_BYTE[dhno_pkg::ADDR_W-1:0];
    localparam logic [dhno_pkg::ADDR_W-1:0] SPARE_ADDR = SPARE_BYTE[dhno_pkg::ADDR_W-1:0];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [dhno_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [31:0] frame_number = '0;
    logic [15:0] shake_frames = '0;
    logic [23:0] shake_intensity = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic        shaking;

    // Per-phase idling switches, and the one-shot long output stall
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit stall_armed = 1'b0;
    bit stall_done = 1'b0;

    int quiet_cycles = 0;
    int decay_settings = 1;

    offset_scoreboard shake_model = new();

    always #(PERIOD / 2) clk = ~clk;

    decaying_hash_noise_offset_generator u_dut (.*);

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge clk) begin
        if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("decaying_hash_noise_offset_generator_tb: FAIL");
                $finish;
            end
        end
    end

    // Offer one transaction, after a random gap if tx_idle is set; hold valid and payload until taken.
    // Valid stays high across back-to-back transactions.
    task send_item(input dhno_pkg::item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= it.mode;
        frame_number    <= it.frame_number;
        shake_frames    <= it.shake_frames;
        shake_intensity <= it.shake_intensity;
        do @(posedge clk); while (!in_ready);
        shake_model.take_item(it);
    endtask

    // Start a shake; the unused frame field carries random bits.
    task start_shake(input logic [15:0] len, input logic [23:0] amp);
        dhno_pkg::item_t it;
        it.mode            = dhno_pkg::MODE_START;
        it.frame_number    = $urandom;
        it.shake_frames    = len;
        it.shake_intensity = amp;
        send_item(it);
    endtask

    // One frame tick; the unused shake fields carry random bits.
    task frame_tick(input logic [31:0] frame);
        dhno_pkg::item_t it;
        it.mode            = dhno_pkg::MODE_TICK;
        it.frame_number    = frame;
        it.shake_frames    = 16'($urandom);
        it.shake_intensity = 24'($urandom);
        send_item(it);
    endtask

    task apb_write(input logic [dhno_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Only the decay register exists; any other address is dropped.
        if (addr == DECAY_ADDR)
            shake_model.load_decay(data[15:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read the decay register back and compare it with the predicted value.
    task decay_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DECAY_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'd0, shake_model.decay_q16})
            shake_model.report($sformatf("decay_factor read %0h expected %0h",
                                         prdata, shake_model.decay_q16));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid, wait for every pending result, then let a start still in
    // flight finish before the block is touched again.
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shake_model.expected_offsets.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed shakes: a start, then a run of ticks that often
    // outlives the shake, with frame numbers that mostly count up. The rest
    // is lone transactions with every field random.
    task run_shakes(input int count);
        int          sent;
        int          r;
        int          ticks;
        int          span;
        logic [15:0] len;
        logic [23:0] amp;
        logic [31:0] frame;
        dhno_pkg::item_t it;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                it.mode            = 1'($urandom_range(0, 1));
                it.frame_number    = $urandom;
                it.shake_frames    = 16'($urandom);
                it.shake_intensity = 24'($urandom);
                send_item(it);
                sent++;
            end else begin
                len = (r < 16) ? 16'($urandom) : 16'($urandom_range(0, 10));
                case ($urandom_range(0, 3))
                    0:       amp = 24'hFF_FFFF;
                    1:       amp = 24'($urandom_range(0, 255));
                    default: amp = 24'($urandom);
                endcase
                start_shake(len, amp);
                span  = (len > 16'd12) ? 12 : int'(len);
                ticks = $urandom_range(1, span + 3);
                frame = $urandom;
                repeat (ticks) begin
                    frame_tick(frame);
                    frame = ($urandom_range(0, 9) == 0) ? $urandom : frame + 32'd1;
                end
                sent += ticks + 1;
            end
        end
    endtask

    // Accept results, after random gaps when rx_idle is set; once per run hold off for a long
    // stretch so that the block fills up and stalls its input.
    initial begin : result_sink
        int                hold;
        dhno_pkg::result_t got;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            hold = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall_armed && !stall_done) begin
                hold += LONG_STALL;
                stall_done = 1'b1;
            end
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.offset_x = offset_x;
            got.offset_y = offset_y;
            got.shaking  = shaking;
            shake_model.check_offsets(got);
        end
    end

    initial begin : stimulus
        logic [15:0] decay_plan [PHASES];
        logic [15:0] decay;
        decay_plan[0] = 16'hFFFF;
        decay_plan[1] = 16'h0000;
        decay_plan[2] = 16'h0001;
        decay_plan[3] = 16'h8000;
        decay_plan[4] = 16'h0000;    // replaced by a random setting
        decay_plan[5] = dhno_pkg::DECAY_RESET;

        // Hold reset, then release it away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset decay of 0.95.
        frame_tick(32'd0);                    // tick before any shake: inactive
        start_shake(16'd0, 24'hFF_FFFF);      // zero-length shake
        frame_tick(32'hFFFF_FFFF);            // still inactive
        start_shake(16'd3, 24'hFF_FFFF);      // full amplitude
        frame_tick(32'd0);
        frame_tick(32'hFFFF_FFFF);
        frame_tick(32'h1234_5678);
        frame_tick($urandom);                 // frames used up: inactive
        start_shake(16'hFFFF, 24'd1);         // longest shake, smallest amplitude
        frame_tick($urandom);
        frame_tick($urandom);
        start_shake(16'd2, 24'd0);            // zero amplitude
        frame_tick($urandom);
        frame_tick($urandom);
        frame_tick($urandom);
        start_shake(16'd4, 24'h80_0000);
        frame_tick(32'hAAAA_AAAA);
        frame_tick(32'h5555_5555);
        frame_tick($urandom);
        frame_tick($urandom);
        start_shake(16'd1, 24'h7F_FFFF);
        start_shake(16'd2, 24'hFF_FFFF);      // restart replaces the pending shake
        frame_tick($urandom);
        frame_tick($urandom);
        frame_tick($urandom);
        settle();

        // A write to the unmapped slot must leave the decay untouched.
        apb_write(SPARE_ADDR, $urandom);
        decay_readback();

        // Random part: one decay setting per phase, idling mixed per phase.
        for (int p = 0; p < PHASES; p++) begin
            tx_idle     = (p % 3) != 0;
            rx_idle     = (p % 2) != 0;
            stall_armed = (p == 2);
            decay       = (p == 4) ? 16'($urandom) : decay_plan[p];
            apb_write(DECAY_ADDR, {16'($urandom), decay});
            decay_readback();
            decay_settings++;
            run_shakes(ITEMS_PER_PHASE);
            settle();
        end

        $display("covered %0d transactions in, %0d results checked (%0d active ticks)",
                 shake_model.items_taken, shake_model.results_checked,
                 shake_model.active_ticks);
        $display("over %0d decay settings, an unmapped write and a %0d-cycle output stall",
                 decay_settings, LONG_STALL);
        if (shake_model.errors == 0)
            $display("decaying_hash_noise_offset_generator_tb: PASS");
        else
            $display("decaying_hash_noise_offset_generator_tb: FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/dhno_pkg.sv
sv/dhno_mul.sv
sv/dhno_seq.sv
sv/decaying_hash_noise_offset_generator.sv
sv/dhno_chk.sv
test/decaying_hash_noise_offset_generator_tb.sv
